// File: hdl/gtr_pkg.sv
// Shared types, codes and helpers for the glyph text renderer.
`default_nettype none

package gtr_pkg;

	// Default geometry and character range
	localparam int GLYPH_W_DEF = 8;
	localparam int GLYPH_H_DEF = 8;
	localparam int CHAR_LO_DEF = 32;
	localparam int CHAR_HI_DEF = 126;

	// Font store geometry
	localparam int FONT_DEPTH = 760;
	localparam int FONT_AW    = 10;

	// Font byte: bit 7 is the leftmost column
	localparam logic [2:0] FONT_MSB = 3'd7;

	localparam logic [12:0] CURSOR_MAX  = 13'h1FFF;
	localparam logic [31:0] TRANSPARENT = 32'hFFFF_FFFF;

	// Request actions
	localparam logic [1:0] ACT_START = 2'd0;
	localparam logic [1:0] ACT_DRAW  = 2'd1;
	localparam logic [1:0] ACT_LOAD  = 2'd2;

	// Control characters
	localparam logic [7:0] CHAR_NUL = 8'd0;
	localparam logic [7:0] CHAR_LF  = 8'd10;
	localparam logic [7:0] CHAR_CR  = 8'd13;

	// Register indexes
	localparam logic [2:0] REG_ORIGIN_X    = 3'd0;
	localparam logic [2:0] REG_ORIGIN_Y    = 3'd1;
	localparam logic [2:0] REG_FG_COLOR    = 3'd2;
	localparam logic [2:0] REG_BG_COLOR    = 3'd3;
	localparam logic [2:0] REG_SCREEN_W    = 3'd4;
	localparam logic [2:0] REG_SCREEN_H    = 3'd5;
	localparam logic [2:0] REG_ROW_PITCH   = 3'd6;
	localparam logic [2:0] REG_PIXEL_BYTES = 3'd7;

	// Controller states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ROW,
		ST_EMIT,
		ST_FLUSH,
		ST_CUR_X,
		ST_CUR_Y
	} state_t;

	// Controller to datapath
	typedef struct packed {
		logic take;
		logic row_setup;
		logic emit_step;
		logic flush;
		logic cur_x;
		logic cur_y;
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic glyph;
		logic advance;
		logic row_clip;
		logic col_end;
		logic row_last;
		logic out_free;
		logic pend_valid;
	} stat_t;

	// Cursor add that saturates at the cursor range
	function automatic logic [12:0] sat_add(input logic [12:0] a, input logic [3:0] b);
		logic [13:0] s;
		s = {1'b0, a} + 14'(b);
		return (s > {1'b0, CURSOR_MAX}) ? CURSOR_MAX : s[12:0];
	endfunction

endpackage

`default_nettype wire

// File: hdl/gtr_ctrl.sv
// Controller state machine of the glyph text renderer.
`default_nettype none

module gtr_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_stall,
	input  wire gtr_pkg::stat_t st,
	output gtr_pkg::cmd_t      cmd
);

	gtr_pkg::state_t state_q, state_nx;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= gtr_pkg::ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	// Next state and commands
	always_comb begin
		state_nx = state_q;
		cmd      = '0;
		in_stall = 1'b1;
		unique case (state_q)
			gtr_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.take = 1'b1;
					if (st.glyph) begin
						state_nx = gtr_pkg::ST_ROW;
					end else if (st.advance) begin
						state_nx = gtr_pkg::ST_CUR_X;
					end
				end
			end
			gtr_pkg::ST_ROW: begin
				// a row below the screen ends the glyph
				if (st.row_clip) begin
					state_nx = gtr_pkg::ST_FLUSH;
				end else begin
					cmd.row_setup = 1'b1;
					state_nx      = gtr_pkg::ST_EMIT;
				end
			end
			gtr_pkg::ST_EMIT: begin
				if (st.out_free) begin
					cmd.emit_step = 1'b1;
					if (st.col_end) begin
						state_nx = st.row_last ? gtr_pkg::ST_FLUSH : gtr_pkg::ST_ROW;
					end
				end
			end
			gtr_pkg::ST_FLUSH: begin
				if (st.out_free) begin
					cmd.flush = 1'b1;
					state_nx  = gtr_pkg::ST_CUR_X;
				end
			end
			gtr_pkg::ST_CUR_X: begin
				cmd.cur_x = 1'b1;
				state_nx  = gtr_pkg::ST_CUR_Y;
			end
			gtr_pkg::ST_CUR_Y: begin
				cmd.cur_y = 1'b1;
				state_nx  = gtr_pkg::ST_IDLE;
			end
			default: begin
				state_nx = gtr_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

// File: hdl/gtr_dp.sv
// Datapath of the glyph text renderer: registers, cursor, font store, pixel writes.
`default_nettype none

module gtr_dp #(
	parameter int GLYPH_W = gtr_pkg::GLYPH_W_DEF,
	parameter int GLYPH_H = gtr_pkg::GLYPH_H_DEF,
	parameter int CHAR_LO = gtr_pkg::CHAR_LO_DEF,
	parameter int CHAR_HI = gtr_pkg::CHAR_HI_DEF
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire gtr_pkg::cmd_t cmd,
	output gtr_pkg::stat_t     st,
	input  wire logic [1:0]    action,
	input  wire logic [7:0]    char_code,
	input  wire logic [9:0]    font_index,
	input  wire logic [7:0]    font_row,
	input  wire logic          wr_en,
	input  wire logic [2:0]    wr_index,
	input  wire logic [31:0]   wr_data,
	output logic               out_valid,
	input  wire logic          out_stall,
	output logic [25:0]        byte_offset,
	output logic [31:0]        pixel_value,
	output logic               last
);

	localparam int CW = (GLYPH_W > 1) ? $clog2(GLYPH_W) : 1;
	localparam int RW = (GLYPH_H > 1) ? $clog2(GLYPH_H) : 1;

	// Configuration registers
	logic [11:0] origin_x_q, origin_y_q;
	logic [31:0] fg_q, bg_q;
	logic [12:0] sw_q, sh_q;
	logic [14:0] pitch_q;
	logic [2:0]  pb_q;

	// Cursor and string state
	logic [12:0] cx_q, cy_q;
	logic        stopped_q;
	logic        wrap_q;

	// Glyph walk
	logic [7:0]    code_q;
	logic [RW-1:0] row_q;
	logic [CW-1:0] col_q;
	logic [25:0]   row_base_q;
	logic [15:0]   col_off_q;
	logic [7:0]    font_q;
	logic          addr_ok_q;

	// Held-back write and output register
	logic        pend_valid_q;
	logic [25:0] pend_off_q;
	logic [31:0] pend_val_q;
	logic        out_valid_q;
	logic [25:0] out_off_q;
	logic [31:0] out_val_q;
	logic        out_last_q;

	logic [7:0] font_mem [gtr_pkg::FONT_DEPTH];

	logic        draw_ok, in_range;
	logic [13:0] py, px;
	logic [27:0] row_prod;
	logic [10:0] font_addr;
	logic        addr_ok;
	logic [7:0]  bits;
	logic        bit_set, write_px, push, out_free;
	logic [25:0] px_off;
	logic [31:0] px_val;
	logic [12:0] nx, ny;

	// Request decode
	assign draw_ok = (action == gtr_pkg::ACT_DRAW) && !stopped_q
		&& (char_code != gtr_pkg::CHAR_NUL) && (char_code != gtr_pkg::CHAR_CR)
		&& (char_code != gtr_pkg::CHAR_LF);
	assign in_range = (char_code >= 8'(CHAR_LO)) && (char_code <= 8'(CHAR_HI));

	// Row setup: screen row, row base offset, font address
	assign py        = {1'b0, cy_q} + 14'(row_q);
	assign row_prod  = 28'(py[12:0]) * 28'(pitch_q);
	assign font_addr = (11'(code_q) - 11'(CHAR_LO)) * 11'(GLYPH_H) + 11'(row_q);
	assign addr_ok   = font_addr < 11'(gtr_pkg::FONT_DEPTH);

	// Column step
	assign px       = {1'b0, cx_q} + 14'(col_q);
	assign bits     = addr_ok_q ? font_q : 8'd0;
	assign bit_set  = bits[gtr_pkg::FONT_MSB - 3'(col_q)];
	assign write_px = (px < {1'b0, sw_q}) && (bit_set || (bg_q != gtr_pkg::TRANSPARENT));
	assign px_off   = row_base_q + 26'(col_off_q);
	assign px_val   = bit_set ? fg_q : bg_q;

	assign out_free = !out_valid_q || !out_stall;
	assign push     = pend_valid_q && ((cmd.emit_step && write_px) || cmd.flush);

	// Cursor advance
	assign nx = gtr_pkg::sat_add(cx_q, 4'(GLYPH_W));
	assign ny = wrap_q ? gtr_pkg::sat_add(cy_q, 4'(GLYPH_H)) : cy_q;

	// Status to the controller
	always_comb begin
		st.glyph      = draw_ok && in_range && (pb_q != 3'd0);
		st.advance    = draw_ok;
		st.row_clip   = py >= {1'b0, sh_q};
		st.col_end    = (px >= {1'b0, sw_q}) || (col_q == CW'(GLYPH_W - 1));
		st.row_last   = row_q == RW'(GLYPH_H - 1);
		st.out_free   = out_free;
		st.pend_valid = pend_valid_q;
	end

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_x_q <= 12'd0;
			origin_y_q <= 12'd0;
			fg_q       <= 32'hFFFF_FFFF;
			bg_q       <= 32'hFFFF_FFFF;
			sw_q       <= 13'd640;
			sh_q       <= 13'd480;
			pitch_q    <= 15'd2560;
			pb_q       <= 3'd4;
		end else if (wr_en) begin
			unique case (wr_index)
				gtr_pkg::REG_ORIGIN_X:    origin_x_q <= wr_data[11:0];
				gtr_pkg::REG_ORIGIN_Y:    origin_y_q <= wr_data[11:0];
				gtr_pkg::REG_FG_COLOR:    fg_q       <= wr_data;
				gtr_pkg::REG_BG_COLOR:    bg_q       <= wr_data;
				gtr_pkg::REG_SCREEN_W:    sw_q       <= wr_data[12:0];
				gtr_pkg::REG_SCREEN_H:    sh_q       <= wr_data[12:0];
				gtr_pkg::REG_ROW_PITCH:   pitch_q    <= wr_data[14:0];
				gtr_pkg::REG_PIXEL_BYTES: pb_q       <= wr_data[2:0];
			endcase
		end
	end

	// Cursor, string state and control characters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cx_q      <= 13'd0;
			cy_q      <= 13'd0;
			stopped_q <= 1'b1;
			wrap_q    <= 1'b0;
		end else if (cmd.take) begin
			unique case (action)
				gtr_pkg::ACT_START: begin
					cx_q      <= 13'(origin_x_q);
					cy_q      <= 13'(origin_y_q);
					stopped_q <= 1'b0;
				end
				gtr_pkg::ACT_DRAW: begin
					if (!stopped_q) begin
						priority if (char_code == gtr_pkg::CHAR_NUL) begin
							stopped_q <= 1'b1;
						end else if (char_code == gtr_pkg::CHAR_CR) begin
							cx_q <= 13'(origin_x_q);
						end else if (char_code == gtr_pkg::CHAR_LF) begin
							cx_q <= 13'(origin_x_q);
							cy_q <= gtr_pkg::sat_add(cy_q, 4'(GLYPH_H));
						end else begin
						end
					end
				end
				default: begin
				end
			endcase
		end else if (cmd.cur_x) begin
			// wrap when the next glyph would not fit
			wrap_q <= ({1'b0, nx} + 14'(GLYPH_W)) > {1'b0, sw_q};
			if (({1'b0, nx} + 14'(GLYPH_W)) > {1'b0, sw_q}) begin
				cx_q <= 13'(origin_x_q);
			end else begin
				cx_q <= nx;
			end
		end else if (cmd.cur_y) begin
			cy_q <= ny;
			if (({1'b0, ny} + 14'(GLYPH_H)) > {1'b0, sh_q}) begin
				stopped_q <= 1'b1;
			end
		end
	end

	// Font store: written by load requests, read once per glyph row
	always_ff @(posedge clk) begin
		if (cmd.take && (action == gtr_pkg::ACT_LOAD)
			&& (font_index < 10'(gtr_pkg::FONT_DEPTH))) begin
			font_mem[font_index] <= font_row;
		end
		if (cmd.row_setup && addr_ok) begin
			font_q <= font_mem[font_addr[gtr_pkg::FONT_AW-1:0]];
		end
	end

	// Glyph walk counters and offsets
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= '0;
		end else if (cmd.take) begin
			row_q <= '0;
		end else if (cmd.row_setup) begin
			col_q <= '0;
		end else if (cmd.emit_step) begin
			col_q <= col_q + CW'(1);
			if (st.col_end) begin
				row_q <= row_q + RW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			code_q <= char_code;
		end
		if (cmd.row_setup) begin
			row_base_q <= row_prod[25:0];
			col_off_q  <= 16'(cx_q) * 16'(pb_q);
			addr_ok_q  <= addr_ok;
		end else if (cmd.emit_step) begin
			col_off_q <= col_off_q + 16'(pb_q);
		end
	end

	// Held-back write and output register valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cmd.emit_step && write_px) begin
				pend_valid_q <= 1'b1;
			end else if (cmd.flush) begin
				pend_valid_q <= 1'b0;
			end
			if (out_free) begin
				out_valid_q <= push;
			end
		end
	end

	// Write payloads; the last write of a glyph leaves on flush
	always_ff @(posedge clk) begin
		if (cmd.emit_step && write_px) begin
			pend_off_q <= px_off;
			pend_val_q <= px_val;
		end
		if (push) begin
			out_off_q  <= pend_off_q;
			out_val_q  <= pend_val_q;
			out_last_q <= cmd.flush;
		end
	end

	assign out_valid   = out_valid_q;
	assign byte_offset = out_off_q;
	assign pixel_value = out_val_q;
	assign last        = out_last_q;

endmodule

`default_nettype wire

// File: hdl/glyph_text_renderer.sv
// Bitmap font text renderer: top level joining controller and datapath.
//
// Requests arrive on in_valid/in_stall with action, char_code, font_index and
// font_row; a request is taken at a clock edge with in_valid high and in_stall
// low. Start, font load, control characters and stopped or unused requests end
// in the idle state; a character outside the font range or with zero pixel_bytes
// also runs the cursor advance. A drawable character holds the input while,
// for each glyph row, the font is read and the offset multiplied and then the
// columns go out one per cycle while the receiver does not stall; a flush and a
// two-step cursor advance follow the rows, and a row below the screen
// ends the walk early. Pixel writes leave on out_valid/out_stall with
// byte_offset, pixel_value and last; last marks the final write of a character.
// One write is held back per glyph so that last can be set, so the first write
// appears after the second written pixel or at the flush.
// A stalled receiver holds the column walk; the output register lets the next
// request be taken while the final write still waits. Registers are written
// through wr_en/wr_index/wr_data, by the user only while no character is in
// progress; the block does not enforce this. Reset clears the cursor, stops the
// string and restores register defaults; font rows stay unknown until loaded.
`default_nettype none

module glyph_text_renderer #(
	parameter int GLYPH_W = gtr_pkg::GLYPH_W_DEF,
	parameter int GLYPH_H = gtr_pkg::GLYPH_H_DEF,
	parameter int CHAR_LO = gtr_pkg::CHAR_LO_DEF,
	parameter int CHAR_HI = gtr_pkg::CHAR_HI_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [1:0]  action,
	input  wire logic [7:0]  char_code,
	input  wire logic [9:0]  font_index,
	input  wire logic [7:0]  font_row,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [25:0]      byte_offset,
	output logic [31:0]      pixel_value,
	output logic             last,
	input  wire logic        wr_en,
	input  wire logic [2:0]  wr_index,
	input  wire logic [31:0] wr_data
);

	gtr_pkg::cmd_t  cmd;
	gtr_pkg::stat_t st;

	gtr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.st       (st),
		.cmd      (cmd)
	);

	gtr_dp #(
		.GLYPH_W (GLYPH_W),
		.GLYPH_H (GLYPH_H),
		.CHAR_LO (CHAR_LO),
		.CHAR_HI (CHAR_HI)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.st          (st),
		.action      (action),
		.char_code   (char_code),
		.font_index  (font_index),
		.font_row    (font_row),
		.wr_en       (wr_en),
		.wr_index    (wr_index),
		.wr_data     (wr_data),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.byte_offset (byte_offset),
		.pixel_value (pixel_value),
		.last        (last)
	);

	// Commands are issued one at a time
	a_cmd_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.take, cmd.row_setup, cmd.emit_step, cmd.flush, cmd.cur_x, cmd.cur_y}))
		else $error("controller issued more than one command");

	// Writes are only produced when the output register can take them
	a_step_room: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit_step || cmd.flush) |-> st.out_free)
		else $error("pixel step without room in the output register");

	// No write is left behind once a new request may be taken
	a_no_pend_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!in_stall |-> !st.pend_valid)
		else $error("held-back write left at request boundary");

	// A flush delivers a write marked last on the next cycle
	a_flush_last: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.flush && st.pend_valid) |=> (out_valid && last))
		else $error("glyph flush did not present its final write");

endmodule

`default_nettype wire

// File: tb/tb.sv
// Self-checking testbench for the glyph text renderer: directed and random text drawing.
`default_nettype none

module tb;

	localparam int GLYPH_W       = gtr_pkg::GLYPH_W_DEF;
	localparam int GLYPH_H       = gtr_pkg::GLYPH_H_DEF;
	localparam int CHAR_LO       = gtr_pkg::CHAR_LO_DEF;
	localparam int CHAR_HI       = gtr_pkg::CHAR_HI_DEF;
	localparam int FONT_DEPTH    = gtr_pkg::FONT_DEPTH;
	localparam int GLYPH_COUNT   = FONT_DEPTH / GLYPH_H;
	localparam int CURSOR_TOP    = 8191;
	localparam int SETTLE_CYCLES = 100;
	localparam int MAX_REPORTS   = 40;
	localparam int RANDOM_ITEMS  = 240;
	localparam int LF_RUN        = 40;

	// Action code with no meaning; the block ignores it
	localparam logic [1:0] ACT_UNUSED = 2'd3;

	// Glyphs loaded by the font setup
	localparam logic [7:0] GL_SPACE = 8'd32;
	localparam logic [7:0] GL_HASH  = 8'd35;
	localparam logic [7:0] GL_A     = 8'd65;
	localparam logic [7:0] GL_TILDE = 8'd126;

	typedef struct packed {
		logic [11:0] org_x;
		logic [11:0] org_y;
		logic [31:0] fg;
		logic [31:0] bg;
		logic [12:0] scr_w;
		logic [12:0] scr_h;
		logic [14:0] pitch;
		logic [2:0]  pbytes;
	} screen_cfg_t;

	typedef struct packed {
		logic [25:0] ofs;
		logic [31:0] value;
		logic        is_last;
	} pixel_write_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [1:0]  action;
	logic [7:0]  char_code;
	logic [9:0]  font_index;
	logic [7:0]  font_row;
	logic        out_valid;
	logic        out_stall;
	logic [25:0] byte_offset;
	logic [31:0] pixel_value;
	logic        last;
	logic        wr_en;
	logic [2:0]  wr_index;
	logic [31:0] wr_data;

	// Renderer shadow state
	screen_cfg_t  cfg_now;
	int unsigned  cur_x, cur_y;
	bit           string_done;
	logic [7:0]   font_mem [FONT_DEPTH];
	bit [FONT_DEPTH-1:0] font_known;
	bit           glyph_ready [GLYPH_COUNT];
	logic [7:0]   ready_glyph [$];
	pixel_write_t pending_writes [$];

	// Run control and tallies
	bit no_idle;
	int hold_cycles;
	int mismatch_count;
	int writes_seen;
	int requests_sent;
	int settings_used;
	int rand_items;

	glyph_text_renderer u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.action(action),
		.char_code(char_code),
		.font_index(font_index),
		.font_row(font_row),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.byte_offset(byte_offset),
		.pixel_value(pixel_value),
		.last(last),
		.wr_en(wr_en),
		.wr_index(wr_index),
		.wr_data(wr_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Cursor add, clamped to the 13-bit range
	function automatic int unsigned cursor_step(input int unsigned v, input int unsigned inc);
		return (v + inc > CURSOR_TOP) ? CURSOR_TOP : v + inc;
	endfunction

	// Shadow of the renderer: update state, queue the pixel writes of one request
	task automatic predict_request(input logic [1:0] act, input logic [7:0] code,
			input logic [9:0] idx, input logic [7:0] rbits);
		int unsigned py, px, gnum;
		int r, c;
		logic [7:0] bits;
		logic [31:0] pv;
		pixel_write_t held;
		bit have_held, paint;
		have_held = 1'b0;
		held = '0;
		case (act)
		gtr_pkg::ACT_START: begin
			cur_x = cfg_now.org_x;
			cur_y = cfg_now.org_y;
			string_done = 1'b0;
		end
		gtr_pkg::ACT_LOAD: begin
			if (idx < FONT_DEPTH) begin
				font_mem[idx] = rbits;
				font_known[idx] = 1'b1;
				gnum = idx / GLYPH_H;
				if (!glyph_ready[gnum] && (&font_known[gnum * GLYPH_H +: GLYPH_H])) begin
					glyph_ready[gnum] = 1'b1;
					ready_glyph.push_back(8'(gnum + CHAR_LO));
				end
			end
		end
		gtr_pkg::ACT_DRAW: begin
			if (!string_done) begin
				if (code == gtr_pkg::CHAR_NUL) begin
					string_done = 1'b1;
				end else if (code == gtr_pkg::CHAR_CR) begin
					cur_x = cfg_now.org_x;
				end else if (code == gtr_pkg::CHAR_LF) begin
					cur_x = cfg_now.org_x;
					cur_y = cursor_step(cur_y, GLYPH_H);
				end else begin
					// glyph body, clipped to the screen; transparent bg skips clear bits
					if (code >= CHAR_LO && code <= CHAR_HI && cfg_now.pbytes != 0) begin
						for (r = 0; r < GLYPH_H; r++) begin
							py = cur_y + r;
							if (py >= cfg_now.scr_h)
								break;
							bits = font_mem[(code - CHAR_LO) * GLYPH_H + r];
							for (c = 0; c < GLYPH_W; c++) begin
								px = cur_x + c;
								if (px >= cfg_now.scr_w)
									break;
								paint = 1'b1;
								pv = '0;
								if (bits[gtr_pkg::FONT_MSB - c])
									pv = cfg_now.fg;
								else if (cfg_now.bg != gtr_pkg::TRANSPARENT)
									pv = cfg_now.bg;
								else
									paint = 1'b0;
								if (paint) begin
									if (have_held)
										pending_writes.push_back(held);
									held.ofs = 26'(py * cfg_now.pitch + px * cfg_now.pbytes);
									held.value = pv;
									held.is_last = 1'b0;
									have_held = 1'b1;
								end
							end
						end
						if (have_held) begin
							held.is_last = 1'b1;
							pending_writes.push_back(held);
						end
					end
					// advance, wrap, and stop once the next line won't fit
					cur_x = cursor_step(cur_x, GLYPH_W);
					if (cur_x + GLYPH_W > cfg_now.scr_w) begin
						cur_x = cfg_now.org_x;
						cur_y = cursor_step(cur_y, GLYPH_H);
					end
					if (cur_y + GLYPH_H > cfg_now.scr_h)
						string_done = 1'b1;
				end
			end
		end
		default: ;
		endcase
	endtask

	// Offer one request, wait for it to be taken, then predict it
	task automatic send_request(input logic [1:0] act, input logic [7:0] code,
			input logic [9:0] idx, input logic [7:0] rbits);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 9);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid   <= 1'b1;
		action     <= act;
		char_code  <= code;
		font_index <= idx;
		font_row   <= rbits;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		requests_sent++;
		predict_request(act, code, idx, rbits);
	endtask

	task automatic draw_char(input logic [7:0] code);
		send_request(gtr_pkg::ACT_DRAW, code, 10'($urandom), 8'($urandom));
	endtask

	task automatic start_text();
		send_request(gtr_pkg::ACT_START, 8'($urandom), 10'($urandom), 8'($urandom));
	endtask

	task automatic load_font(input logic [9:0] idx, input logic [7:0] rbits);
		send_request(gtr_pkg::ACT_LOAD, 8'($urandom), idx, rbits);
	endtask

	// Wait for every expected write, then let any write-free character finish
	task automatic drain_block();
		in_valid <= 1'b0;
		while (pending_writes.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Write all registers while the block is idle
	task automatic apply_screen_cfg(input screen_cfg_t cfg);
		int i;
		drain_block();
		for (i = 0; i < 8; i++) begin
			wr_en    <= 1'b1;
			wr_index <= 3'(i);
			case (3'(i))
			gtr_pkg::REG_ORIGIN_X:    wr_data <= 32'(cfg.org_x);
			gtr_pkg::REG_ORIGIN_Y:    wr_data <= 32'(cfg.org_y);
			gtr_pkg::REG_FG_COLOR:    wr_data <= cfg.fg;
			gtr_pkg::REG_BG_COLOR:    wr_data <= cfg.bg;
			gtr_pkg::REG_SCREEN_W:    wr_data <= 32'(cfg.scr_w);
			gtr_pkg::REG_SCREEN_H:    wr_data <= 32'(cfg.scr_h);
			gtr_pkg::REG_ROW_PITCH:   wr_data <= 32'(cfg.pitch);
			gtr_pkg::REG_PIXEL_BYTES: wr_data <= 32'(cfg.pbytes);
			default:                  wr_data <= '0;
			endcase
			@(posedge clk);
		end
		wr_en <= 1'b0;
		cfg_now = cfg;
		settings_used++;
	endtask

	function automatic screen_cfg_t random_cfg();
		screen_cfg_t c;
		case ($urandom_range(0, 5))
		0:       c.org_x = 12'd0;
		1:       c.org_x = 12'd4095;
		default: c.org_x = 12'($urandom_range(0, 48));
		endcase
		case ($urandom_range(0, 5))
		0:       c.org_y = 12'd0;
		1:       c.org_y = 12'd4095;
		default: c.org_y = 12'($urandom_range(0, 40));
		endcase
		case ($urandom_range(0, 5))
		0:       c.fg = 32'd0;
		1:       c.fg = gtr_pkg::TRANSPARENT;
		default: c.fg = $urandom;
		endcase
		case ($urandom_range(0, 5))
		0, 1, 2: c.bg = gtr_pkg::TRANSPARENT;
		3:       c.bg = 32'd0;
		default: c.bg = $urandom;
		endcase
		case ($urandom_range(0, 7))
		0:       c.scr_w = 13'd0;
		1:       c.scr_w = 13'd4096;
		default: c.scr_w = 13'($urandom_range(8, 96));
		endcase
		case ($urandom_range(0, 7))
		0:       c.scr_h = 13'd0;
		1:       c.scr_h = 13'd4096;
		default: c.scr_h = 13'($urandom_range(8, 64));
		endcase
		case ($urandom_range(0, 4))
		0:       c.pitch = 15'd0;
		1:       c.pitch = 15'd16384;
		default: c.pitch = 15'($urandom_range(0, 16384));
		endcase
		c.pbytes = 3'($urandom_range(0, 4));
		return c;
	endfunction

	// Characters for random strings; drawable ones only from loaded glyphs
	function automatic logic [7:0] pick_char();
		int sel;
		logic [7:0] code;
		sel = $urandom_range(0, 99);
		if (sel < 62)
			code = ready_glyph[$urandom_range(0, ready_glyph.size() - 1)];
		else if (sel < 72)
			code = gtr_pkg::CHAR_CR;
		else if (sel < 82)
			code = gtr_pkg::CHAR_LF;
		else if (sel < 91)
			code = 8'($urandom_range(127, 255));
		else if (sel < 94)
			code = 8'($urandom_range(1, 9));
		else if (sel < 97)
			code = 8'($urandom_range(14, 31));
		else
			code = gtr_pkg::CHAR_NUL;
		return code;
	endfunction

	task automatic load_glyph_rows(input logic [7:0] code, input logic [63:0] rows);
		int r;
		for (r = 0; r < GLYPH_H; r++)
			load_font(10'((code - CHAR_LO) * GLYPH_H + r), rows[63 - 8 * r -: 8]);
	endtask

	// Font setup: blank, full, a letter and a random glyph, plus loads past the store
	task automatic load_test_font();
		load_glyph_rows(GL_SPACE, 64'h0);
		load_glyph_rows(GL_TILDE, '1);
		load_glyph_rows(GL_A, 64'h183C_6666_7E66_6600);
		load_glyph_rows(GL_HASH, {$urandom, $urandom});
		load_font(10'd760, 8'hFF);
		load_font(10'd1023, 8'h00);
	endtask

	task automatic test_reset_defaults();
		start_text();
		draw_char(GL_A);
		draw_char(GL_TILDE);
		draw_char(GL_SPACE);
		draw_char(gtr_pkg::CHAR_NUL);
		draw_char(GL_A);
		send_request(ACT_UNUSED, 8'hFF, 10'h3FF, 8'hFF);
	endtask

	task automatic test_control_chars();
		apply_screen_cfg('{org_x: 12'd16, org_y: 12'd8, fg: 32'h00FF_00FF, bg: 32'd0,
			scr_w: 13'd80, scr_h: 13'd40, pitch: 15'd320, pbytes: 3'd4});
		start_text();
		draw_char(GL_A);
		draw_char(gtr_pkg::CHAR_CR);
		draw_char(GL_HASH);
		draw_char(gtr_pkg::CHAR_LF);
		draw_char(GL_SPACE);
		draw_char(8'd200);
		draw_char(8'd31);
		draw_char(8'd255);
		send_request(ACT_UNUSED, 8'h00, 10'h000, 8'h00);
		draw_char(GL_A);
		draw_char(GL_TILDE);
		draw_char(GL_A);
	endtask

	// Far corner of the largest screen, then zero pitch with one byte per pixel
	task automatic test_screen_corner();
		apply_screen_cfg('{org_x: 12'd4095, org_y: 12'd4095, fg: $urandom, bg: 32'h1234_5678,
			scr_w: 13'd4096, scr_h: 13'd4096, pitch: 15'd16384, pbytes: 3'd4});
		start_text();
		draw_char(GL_TILDE);
		apply_screen_cfg('{org_x: 12'd0, org_y: 12'd0, fg: 32'hDEAD_BEEF,
			bg: gtr_pkg::TRANSPARENT,
			scr_w: 13'd4096, scr_h: 13'd4096, pitch: 15'd0, pbytes: 3'd1});
		start_text();
		draw_char(GL_A);
	endtask

	task automatic test_degenerate_sizes();
		apply_screen_cfg('{org_x: 12'd0, org_y: 12'd0, fg: '1, bg: 32'd0,
			scr_w: 13'd0, scr_h: 13'd0, pitch: 15'd2560, pbytes: 3'd4});
		start_text();
		draw_char(GL_TILDE);
		apply_screen_cfg('{org_x: 12'd8, org_y: 12'd8, fg: '1, bg: 32'd0,
			scr_w: 13'd640, scr_h: 13'd480, pitch: 15'd2560, pbytes: 3'd0});
		start_text();
		draw_char(GL_A);
		draw_char(GL_TILDE);
	endtask

	// A run of line feeds moves cursor_y far down with no stop test; a glyph lands there
	task automatic test_line_feeds();
		int k;
		apply_screen_cfg('{org_x: 12'd0, org_y: 12'd3700, fg: '1, bg: 32'd0,
			scr_w: 13'd640, scr_h: 13'd4096, pitch: 15'd2560, pbytes: 3'd4});
		start_text();
		no_idle = 1'b1;
		for (k = 0; k < LF_RUN; k++)
			draw_char(gtr_pkg::CHAR_LF);
		no_idle = 1'b0;
		draw_char(GL_TILDE);
	endtask

	// Receiver holds off while characters keep coming
	task automatic test_output_backpressure();
		apply_screen_cfg('{org_x: 12'd0, org_y: 12'd0, fg: 32'hCAFE_F00D, bg: 32'h0000_0001,
			scr_w: 13'd640, scr_h: 13'd480, pitch: 15'd2560, pbytes: 3'd4});
		hold_cycles = 400;
		no_idle = 1'b1;
		start_text();
		draw_char(GL_TILDE);
		draw_char(GL_A);
		draw_char(GL_HASH);
		draw_char(GL_SPACE);
		draw_char(GL_TILDE);
		draw_char(GL_A);
		no_idle = 1'b0;
	endtask

	// One string: start, characters with some noise, maybe a terminator
	task automatic run_text_line();
		int len, k, sel;
		logic [7:0] g;
		start_text();
		rand_items++;
		len = $urandom_range(2, 14);
		for (k = 0; k < len; k++) begin
			sel = $urandom_range(0, 99);
			if (sel < 3) begin
				send_request(ACT_UNUSED, 8'($urandom), 10'($urandom), 8'($urandom));
			end else if (sel < 6) begin
				load_font(10'($urandom), 8'($urandom));
				rand_items++;
			end else if (sel < 9) begin
				g = ready_glyph[$urandom_range(0, ready_glyph.size() - 1)];
				load_font(10'((g - CHAR_LO) * GLYPH_H + $urandom_range(0, GLYPH_H - 1)),
					8'($urandom));
				rand_items++;
			end else begin
				draw_char(pick_char());
				rand_items++;
			end
		end
		if ($urandom_range(0, 1) == 1) begin
			draw_char(gtr_pkg::CHAR_NUL);
			rand_items++;
		end
	endtask

	task automatic test_random_strings();
		int n;
		logic [7:0] g;
		while (rand_items < RANDOM_ITEMS) begin
			apply_screen_cfg(random_cfg());
			no_idle = ($urandom_range(0, 3) == 0);
			// now and then bring in a fresh glyph
			if ($urandom_range(0, 2) == 0 && ready_glyph.size() < GLYPH_COUNT) begin
				g = 8'($urandom_range(CHAR_LO, CHAR_HI));
				if (!glyph_ready[g - CHAR_LO]) begin
					load_glyph_rows(g, {$urandom, $urandom});
					rand_items += GLYPH_H;
				end
			end
			n = $urandom_range(2, 4);
			repeat (n) run_text_line();
		end
		no_idle = 1'b0;
	endtask

	// Output side: random stalls after writes, plus a long hold on request
	initial begin : write_sink
		int stall_left, n;
		stall_left = 0;
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_cycles > 0) begin
				n = hold_cycles;
				hold_cycles = 0;
				out_stall <= 1'b1;
				repeat (n) @(posedge clk);
				out_stall <= 1'b0;
				stall_left = 0;
			end else if (stall_left > 0) begin
				stall_left--;
				if (stall_left == 0)
					out_stall <= 1'b0;
			end else if ((out_valid && !out_stall) || $urandom_range(0, 7) == 0) begin
				stall_left = no_idle ? 0 : $urandom_range(0, 9);
				if (stall_left > 0)
					out_stall <= 1'b1;
			end
		end
	end

	// Compare each accepted write with the oldest expected one
	always @(posedge clk) begin : write_check
		pixel_write_t want;
		if (arst_n && out_valid && !out_stall) begin
			writes_seen++;
			if (pending_writes.size() == 0) begin
				mismatch_count++;
				if (mismatch_count < MAX_REPORTS)
					$display("%0t: unexpected write offset %h value %h last %b",
						$time, byte_offset, pixel_value, last);
			end else begin
				want = pending_writes.pop_front();
				if (byte_offset !== want.ofs) begin
					mismatch_count++;
					if (mismatch_count < MAX_REPORTS)
						$display("%0t: byte_offset expected %h actual %h",
							$time, want.ofs, byte_offset);
				end
				if (pixel_value !== want.value) begin
					mismatch_count++;
					if (mismatch_count < MAX_REPORTS)
						$display("%0t: pixel_value expected %h actual %h",
							$time, want.value, pixel_value);
				end
				if (last !== want.is_last) begin
					mismatch_count++;
					if (mismatch_count < MAX_REPORTS)
						$display("%0t: last expected %b actual %b",
							$time, want.is_last, last);
				end
			end
		end
	end

	initial begin : stimulus
		cfg_now = '{org_x: 12'd0, org_y: 12'd0, fg: gtr_pkg::TRANSPARENT,
			bg: gtr_pkg::TRANSPARENT,
			scr_w: 13'd640, scr_h: 13'd480, pitch: 15'd2560, pbytes: 3'd4};
		cur_x = 0;
		cur_y = 0;
		string_done = 1'b1;
		font_known = '0;
		foreach (glyph_ready[i])
			glyph_ready[i] = 1'b0;
		no_idle = 1'b0;
		hold_cycles = 0;
		mismatch_count = 0;
		writes_seen = 0;
		requests_sent = 0;
		settings_used = 0;
		rand_items = 0;

		arst_n     <= 1'b0;
		in_valid   <= 1'b0;
		action     <= gtr_pkg::ACT_START;
		char_code  <= gtr_pkg::CHAR_NUL;
		font_index <= '0;
		font_row   <= '0;
		wr_en      <= 1'b0;
		wr_index   <= gtr_pkg::REG_ORIGIN_X;
		wr_data    <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		load_test_font();
		test_reset_defaults();
		test_control_chars();
		test_screen_corner();
		test_degenerate_sizes();
		test_line_feeds();
		test_output_backpressure();
		test_random_strings();
		drain_block();

		$display("Sent %0d requests over %0d register settings; %0d pixel writes checked.",
			requests_sent, settings_used, writes_seen);
		$display("Included control characters, screen corner, zero sizes, a long run of %s",
			"line feeds and a long output hold.");
		if (mismatch_count == 0) begin
			$display("== PASS ==");
		end else begin
			$display("%0d mismatches", mismatch_count);
			$display("== FAIL ==");
		end
		$finish;
	end

	// Guard against a hung handshake
	initial begin : watchdog
		#50_000_000;
		$display("Timed out with %0d writes still expected", pending_writes.size());
		$display("== FAIL ==");
		$finish;
	end

endmodule

`default_nettype wire
